### design/lru_key_value_cache_assert.svh
// ----------------------------------------------------------------------------
// lru key-value cache assertion macros
// shared property wrappers clocked on clk_i and disabled while in reset
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// same-cycle implication
`define LKVC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lru cache check failed");

// next-cycle implication
`define LKVC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lru cache check failed");

`endif

### design/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// item types, cell control bundle and constants of the lru key-value cache
// ----------------------------------------------------------------------------
`default_nettype none

package lkvc_pkg;

  localparam int unsigned CapW = 5;
  localparam logic [CapW-1:0] CapReset = 5'd16;

  localparam logic FuncGet = 1'b0;
  localparam logic FuncPut = 1'b1;

  // input item
  typedef struct packed {
    logic               func;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } lkvc_in_t;

  // result item
  typedef struct packed {
    logic               found;
    logic signed [31:0] read_value;
    logic               evicted;
    logic signed [31:0] evicted_key;
  } lkvc_out_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic cmp_en;      // latch key compare
    logic upd_en;      // apply recency update
    logic live;        // slot index below entry count
    logic is_tail;     // slot receives the new most recent entry
    logic below_tail;  // slot may take its upper neighbor
    logic shift_all;   // eviction: every slot below tail shifts
  } lkvc_ctrl_t;

endpackage

`default_nettype wire

### design/lkvc_cell.sv
// ----------------------------------------------------------------------------
// lkvc_cell
// one slot of the recency chain: holds a key/value pair, compares the key and
// takes its upper neighbor's pair when the chain closes a gap
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_cell (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire lkvc_pkg::lkvc_ctrl_t ctrl_i,
  input  wire logic [31:0]        op_key_i,
  input  wire logic [31:0]        new_key_i,
  input  wire logic [31:0]        new_value_i,
  input  wire logic [31:0]        up_key_i,
  input  wire logic [31:0]        up_value_i,
  input  wire logic               chain_i,
  output logic                    chain_o,
  output logic                    match_o,
  output logic [31:0]             key_o,
  output logic [31:0]             value_o
);
  import lkvc_pkg::*;

  logic [31:0] key_q;
  logic [31:0] value_q;
  logic        match_q;
  logic        hit_incl;

  // hit at this slot or any less recent one
  assign hit_incl = chain_i | match_q;
  assign chain_o  = hit_incl;
  assign match_o  = match_q;
  assign key_o    = key_q;
  assign value_o  = value_q;

  // compare stage result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctrl_i.cmp_en) begin
      match_q <= ctrl_i.live && (key_q == op_key_i);
    end
  end

  // slot contents: load the new entry at the tail or shift down
  always_ff @(posedge clk_i) begin
    if (ctrl_i.upd_en) begin
      priority if (ctrl_i.is_tail) begin
        key_q   <= new_key_i;
        value_q <= new_value_i;
      end else if (ctrl_i.below_tail && (ctrl_i.shift_all || hit_incl)) begin
        key_q   <= up_key_i;
        value_q <= up_value_i;
      end
    end
  end

endmodule

`default_nettype wire

### design/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// fully associative key-value cache with least-recently-used replacement,
// built as a chain of slots kept in recency order (slot 0 least recent)
// ----------------------------------------------------------------------------
// sequence: item held in the operation register, key compared in the compare
//   state, chain shifted and result registered in the update state, which
//   waits on output stall; a new item is taken only in idle or on update
// reset: entry count cleared, capacity register set to 16, no slot clearing
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire lkvc_pkg::lkvc_in_t    in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output lkvc_pkg::lkvc_out_t        out_data_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [lkvc_pkg::CapW-1:0] cfg_data_i
);
  import lkvc_pkg::*;

  `include "lru_key_value_cache_assert.svh"

  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CmpW = (CntW > CapW) ? CntW : CapW;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CapW-1:0] cap_q;
  lkvc_in_t        op_q;
  logic            out_valid_q;
  lkvc_out_t       out_data_q;

  logic [MAX_ENTRIES-1:0] match_vec;
  logic [MAX_ENTRIES-1:0] chain_out;
  logic [31:0]            key_arr   [MAX_ENTRIES];
  logic [31:0]            value_arr [MAX_ENTRIES];

  logic            accept;
  logic            out_free;
  logic            upd_go;
  logic            hit;
  logic            is_put;
  logic            evict;
  logic            insert;
  logic [31:0]     sel_value;
  logic [31:0]     new_value;
  logic [CntW-1:0] tail;
  logic [CmpW-1:0] cap_ext;
  logic [CmpW-1:0] eff_cap;
  logic [CmpW-1:0] cnt_ext;

  // configuration port, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_q <= cfg_data_i;
    end
  end

  // handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign upd_go     = (state_q == ST_UPD) && out_free;
  assign in_stall_o = !((state_q == ST_IDLE) || upd_go);
  assign accept     = in_valid_i && !in_stall_o;

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_CMP;
      ST_CMP:  state_d = ST_UPD;
      ST_UPD: begin
        if (upd_go) state_d = accept ? ST_CMP : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // operation register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= in_data_i;
    end
  end

  // effective capacity, clamped to one and to the slot count
  assign cap_ext = CmpW'(cap_q);
  assign cnt_ext = CmpW'(cnt_q);
  always_comb begin
    eff_cap = cap_ext;
    if (cap_ext == '0) eff_cap = CmpW'(1);
    if (cap_ext > CmpW'(MAX_ENTRIES)) eff_cap = CmpW'(MAX_ENTRIES);
  end

  // hit value select over the one-hot match vector
  always_comb begin
    sel_value = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (match_vec[i]) sel_value = sel_value | value_arr[i];
    end
  end

  assign hit       = chain_out[MAX_ENTRIES-1];
  assign is_put    = (op_q.func == FuncPut);
  assign evict     = !hit && is_put && (cnt_ext >= eff_cap) && (cnt_q != '0);
  assign insert    = !hit && is_put && !evict;
  assign new_value = (hit && !is_put) ? sel_value : op_q.value;
  assign tail      = (hit || evict) ? cnt_q - CntW'(1) : cnt_q;

  // entry count
  always_comb begin
    cnt_d = cnt_q;
    if (upd_go && insert) cnt_d = cnt_q + CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // slot chain
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    lkvc_ctrl_t  ctrl;
    logic [31:0] up_key;
    logic [31:0] up_value;
    logic        chain_in;

    assign ctrl.cmp_en     = (state_q == ST_CMP);
    assign ctrl.upd_en     = upd_go && (hit || is_put);
    assign ctrl.live       = CntW'(g) < cnt_q;
    assign ctrl.is_tail    = CntW'(g) == tail;
    assign ctrl.below_tail = CntW'(g) < tail;
    assign ctrl.shift_all  = evict;

    if (g == MAX_ENTRIES - 1) begin : g_top
      assign up_key   = '0;
      assign up_value = '0;
    end else begin : g_mid
      assign up_key   = key_arr[g+1];
      assign up_value = value_arr[g+1];
    end

    if (g == 0) begin : g_first
      assign chain_in = 1'b0;
    end else begin : g_rest
      assign chain_in = chain_out[g-1];
    end

    lkvc_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .op_key_i    (op_q.key),
      .new_key_i   (op_q.key),
      .new_value_i (new_value),
      .up_key_i    (up_key),
      .up_value_i  (up_value),
      .chain_i     (chain_in),
      .chain_o     (chain_out[g]),
      .match_o     (match_vec[g]),
      .key_o       (key_arr[g]),
      .value_o     (value_arr[g])
    );
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (upd_go) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_go) begin
      out_data_q.found       <= hit;
      out_data_q.read_value  <= hit ? new_value : '0;
      out_data_q.evicted     <= evict;
      out_data_q.evicted_key <= evict ? key_arr[0] : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // checks
  `LKVC_ASSERT_IMPL(a_unique_match, state_q == ST_UPD, $onehot0(match_vec))
  `LKVC_ASSERT_NEXT(a_accept_to_cmp, accept, state_q == ST_CMP)
  `LKVC_ASSERT_NEXT(a_evict_keeps_count, upd_go && evict, cnt_q == $past(cnt_q))
  `LKVC_ASSERT_IMPL(a_result_from_upd, $rose(out_valid_q), $past(state_q) == ST_UPD)

endmodule

`default_nettype wire

### test/tb_lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache
// self-checking bench for the lru key-value cache: get/put items go in through
// bursty valid/stall traffic, a recency-ordered shadow of the cache predicts
// found, read value and eviction for each item, and every result is matched
// in order; the capacity register is swept over its range, out-of-range
// values included
// ----------------------------------------------------------------------------
`default_nettype none

module tb_lru_key_value_cache;
  timeunit 1ns;
  timeprecision 1ps;

  import lkvc_pkg::*;

  localparam int unsigned Slots = 16;
  localparam logic [31:0] CORNER_KEYS [0:5] = '{
    32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000,
    32'hffff_ffff, 32'haaaa_aaaa, 32'h5555_5555
  };

  // shadow of the cache contents plus the queue of results still owed
  class lru_tracker;
    logic [31:0]     keys [Slots];
    logic [31:0]     vals [Slots];
    int unsigned     used;
    logic [CapW-1:0] capacity;
    lkvc_out_t       owed_results [$];
    int unsigned     mismatches;

    function new();
      used       = 0;
      capacity   = CapReset;
      mismatches = 0;
    endfunction

    function void set_capacity(logic [CapW-1:0] c);
      capacity = c;
    endfunction

    function int unsigned pending();
      return owed_results.size();
    endfunction

    // remove slot idx and close the gap toward the least recent end
    function void close_gap(int unsigned idx);
      for (int unsigned i = idx; i + 1 < used; i++) begin
        keys[i] = keys[i+1];
        vals[i] = vals[i+1];
      end
      if (used > 0) used--;
    endfunction

    // one accepted item: update the shadow, queue the result it must give
    function void note_access(lkvc_in_t it);
      lkvc_out_t   res;
      bit          hit;
      int unsigned hit_idx;
      int unsigned limit;
      logic [31:0] stored;
      res     = '0;
      hit     = 1'b0;
      hit_idx = 0;
      for (int unsigned i = 0; i < used; i++) begin
        if (!hit && keys[i] == it.key) begin
          hit     = 1'b1;
          hit_idx = i;
        end
      end
      if (hit) begin
        stored = (it.func == FuncPut) ? it.value : vals[hit_idx];
        close_gap(hit_idx);
        keys[used] = it.key;
        vals[used] = stored;
        used++;
        res.found      = 1'b1;
        res.read_value = stored;
      end else if (it.func == FuncPut) begin
        // capacity zero acts as one, anything above the slot count as full size
        limit = (capacity == 0) ? 1 : ((capacity > Slots) ? Slots : capacity);
        if (used >= limit && used > 0) begin
          res.evicted     = 1'b1;
          res.evicted_key = keys[0];
          close_gap(0);
        end
        if (used < Slots) begin
          keys[used] = it.key;
          vals[used] = it.value;
          used++;
        end
      end
      owed_results.push_back(res);
    endfunction

    function void flag(string what, lkvc_out_t exp, lkvc_out_t act);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s: exp found=%0b rd=%h ev=%0b evk=%h, got found=%0b rd=%h ev=%0b evk=%h",
                 $time, what, exp.found, exp.read_value, exp.evicted, exp.evicted_key,
                 act.found, act.read_value, act.evicted, act.evicted_key);
    endfunction

    // one accepted result against the oldest owed one
    function void check_reply(lkvc_out_t act);
      lkvc_out_t exp;
      if (owed_results.size() == 0) begin
        flag("result with nothing owed", '0, act);
        return;
      end
      exp = owed_results.pop_front();
      if (act.found !== exp.found || act.read_value !== exp.read_value ||
          act.evicted !== exp.evicted || act.evicted_key !== exp.evicted_key)
        flag("result mismatch", exp, act);
    endfunction
  endclass

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_stall_o;
  lkvc_in_t        in_data_i;
  logic            out_valid_o;
  logic            out_stall_i;
  lkvc_out_t       out_data_o;
  logic            cfg_valid_i;
  logic            cfg_ready_o;
  logic [CapW-1:0] cfg_data_i;

  lru_tracker  board = new();
  int unsigned burst_left = 0;
  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;
  int unsigned run_left = 0;
  int unsigned stall_tick = 0;
  bit          run_hold = 1'b0;
  logic [31:0] key_pool [$];

  lru_key_value_cache #(
    .MAX_ENTRIES (Slots)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // receiver stall: free-running, random, periodic and long-run modes
  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(20, 80);
    end
    mode_left--;
    stall_tick++;
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 99) < 35);
      2: out_stall_i <= (stall_tick % 3 == 0);
      default: begin
        if (run_left == 0) begin
          run_hold = !run_hold;
          run_left = $urandom_range(1, 8);
        end
        run_left--;
        out_stall_i <= run_hold;
      end
    endcase
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_reply(out_data_o);
  end

  function automatic lkvc_in_t access(logic f, logic [31:0] k, logic [31:0] v);
    lkvc_in_t it;
    it.func  = f;
    it.key   = k;
    it.value = v;
    return it;
  endfunction

  // one item, with a random gap whenever a burst runs out
  task automatic send_item(lkvc_in_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = $urandom_range(0, 5);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    board.note_access(it);
  endtask

  // hold off until every owed result is back and the pipe has settled
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_capacity(logic [CapW-1:0] c);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= c;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_capacity(c);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // random traffic over a small key pool so hits and evictions are common
  task automatic run_phase(logic [CapW-1:0] c, int unsigned n);
    int unsigned pool_size;
    int unsigned r;
    lkvc_in_t    it;
    wait_drained();
    write_capacity(c);
    key_pool.delete();
    pool_size = $urandom_range(2, 24);
    for (int unsigned i = 0; i < pool_size; i++)
      key_pool.push_back(($urandom_range(0, 9) == 0) ? CORNER_KEYS[$urandom_range(0, 5)]
                                                      : $urandom);
    for (int unsigned i = 0; i < n; i++) begin
      it.func = ($urandom_range(0, 99) < 55) ? FuncPut : FuncGet;
      r = $urandom_range(0, 99);
      if (r < 80)      it.key = key_pool[$urandom_range(0, pool_size - 1)];
      else if (r < 88) it.key = CORNER_KEYS[$urandom_range(0, 5)];
      else             it.key = $urandom;
      it.value = $urandom;
      send_item(it);
      if ($urandom_range(0, 99) == 0) wait_drained();
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: two-entry cache, corner keys and values, hits, updates, evictions
    write_capacity(5'd2);
    send_item(access(FuncGet, 32'h0000_0000, 32'h1234_5678));  // get on empty cache
    send_item(access(FuncPut, 32'h8000_0000, 32'h7fff_ffff));
    send_item(access(FuncPut, 32'h7fff_ffff, 32'h8000_0000));
    send_item(access(FuncGet, 32'h8000_0000, 32'hffff_ffff));  // hit, value ignored
    send_item(access(FuncPut, 32'h0000_0000, 32'h0000_0000));  // evicts max key
    send_item(access(FuncPut, 32'h8000_0000, 32'hffff_ffff));  // hit, value update
    send_item(access(FuncGet, 32'h7fff_ffff, 32'h0000_0000));  // miss after eviction
    send_item(access(FuncPut, 32'hffff_ffff, 32'h0000_0001));
    send_item(access(FuncGet, 32'hffff_ffff, 32'h0000_0000));
    send_item(access(FuncPut, 32'haaaa_aaaa, 32'h5555_5555));
    send_item(access(FuncPut, 32'h5555_5555, 32'haaaa_aaaa));
    send_item(access(FuncGet, 32'haaaa_aaaa, 32'h0000_0000));
    send_item(access(FuncGet, 32'h5555_5555, 32'h0000_0000));

    // capacity zero acts as one, set while two entries are held
    wait_drained();
    write_capacity(5'd0);
    send_item(access(FuncPut, 32'h0000_0001, 32'h0000_0011));
    send_item(access(FuncPut, 32'h0000_0002, 32'h0000_0022));
    send_item(access(FuncGet, 32'h0000_0002, 32'h0000_0000));
    send_item(access(FuncGet, 32'h0000_0001, 32'h0000_0000));
    send_item(access(FuncPut, 32'h0000_0002, 32'h0000_0033));

    // random phases over the capacity range, out-of-range settings included
    run_phase(5'd16, 64);
    run_phase(5'd1,  60);
    run_phase(5'd31, 64);
    run_phase(5'd4,  60);
    run_phase(5'd17, 64);
    run_phase(5'd8,  60);
    run_phase(5'd0,  50);
    run_phase(5'd16, 64);
    run_phase(5'd3,  60);
    run_phase(5'd12, 60);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2ms;
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
+incdir+design
design/lkvc_pkg.sv
design/lkvc_cell.sv
design/lru_key_value_cache.sv
test/tb_lru_key_value_cache.sv
